### rtl/ffa_pkg.sv
// Package: constants, types and codes for the first-fit allocator.
package ffa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int ADDR_BITS    = 16;
    localparam int IDX_BITS     = $clog2(MAX_SEGMENTS);
    localparam int CNT_BITS     = $clog2(MAX_SEGMENTS + 1);
    // start, size, free mark packed into one table word
    localparam int SEG_BITS     = 2 * ADDR_BITS + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTALLOC = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [0:0] CFG_MEM_BYTES     = 1'b0;
    localparam logic [0:0] CFG_ELEMENT_BYTES = 1'b1;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
    } seg_t;

    typedef enum logic [3:0] {
        S_INIT,      // rewrite entry 0 as one free segment
        S_IDLE,
        S_CHECK,     // size check on the product
        S_SCAN_RD,   // issue read of entry idx
        S_SCAN_EV,   // evaluate entry idx
        S_LO_RD,     // read lower neighbor of a freed entry
        S_LO_EV,     // evaluate lower neighbor
        S_HI_RD,     // read upper neighbor
        S_HI_EV,     // evaluate upper neighbor
        S_MERGE_WR,  // write merged entry
        S_SHIFT_RD,  // read entry for a move
        S_SHIFT_WR,  // write the moved entry
        S_INS,       // write split remainder
        S_OUT        // result waiting on the output channel
    } state_t;

endpackage

### rtl/ffa_ram.sv
// Generic single-port RAM with registered read.
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### rtl/first_fit_allocator_coalescing_top.sv
// Top level of the first-fit segment allocator with coalescing on free.
//
// Input channel (valid/ready): one word per request. func = 0 allocates
// elem_count * element_bytes bytes from the first free segment that fits,
// splitting off any remainder as a free segment just after it (ST_FULL if the
// table has no room for it). func = 1 frees the allocated segment that starts
// at base_addr and merges it with free neighbors. Each request gives exactly
// one result word on the output channel: status, granted_addr, granted_bytes
// and used_bytes. The table is in one single-port RAM with registered read, so
// a request takes a size check, a read and an evaluation per entry scanned, on
// a free neighbor reads and evaluations and a merge write, a read and a write
// per entry moved by a split or merge, and a remainder write on a split. Scanned
// plus moved entries stay within MAX_SEGMENTS; a bad size goes straight from the
// size check to the result. The next word is taken the cycle after the result
// leaves. The result sits in output registers until taken and in_ready stays
// low, so a stalled receiver simply holds the block. Reset and every write of
// mem_bytes rewrite entry 0 as one free segment and set the segment count to
// one; entries at or above the count are never read. The user must write the
// configuration (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce it.
module first_fit_allocator_coalescing_top
    import ffa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [15:0] elem_count,
    input  logic [15:0] base_addr,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] granted_addr,
    output logic [15:0] granted_bytes,
    output logic [15:0] used_bytes
);

    state_t state_reg, state_next;

    logic [15:0]          mem_bytes_reg;
    logic [6:0]           elem_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [ADDR_BITS-1:0] total_reg, total_next;
    logic [IDX_BITS-1:0]  idx_reg, idx_next;     // scan index
    logic [IDX_BITS-1:0]  hit_reg, hit_next;     // entry found
    logic [CNT_BITS-1:0]  src_reg, src_next;     // move source
    logic [CNT_BITS-1:0]  dst_reg, dst_next;     // move destination
    logic                 up_reg, up_next;       // 1: shift up (insert)
    logic                 lo_mg_reg, lo_mg_next; // merged with lower neighbor
    logic                 hi_mg_reg, hi_mg_next; // merged with upper neighbor
    logic                 func_reg;
    logic [15:0]          base_reg;
    logic [22:0]          want_reg;
    seg_t                 cur_reg, cur_next;     // segment being built
    seg_t                 rem_reg, rem_next;     // split remainder
    logic [1:0]           st_reg, st_next;
    logic [15:0]          ga_reg, ga_next, gb_reg, gb_next;

    logic                 ram_we;
    logic [IDX_BITS-1:0]  ram_addr;
    seg_t                 ram_wdata, ram_rdata;
    logic [SEG_BITS-1:0]  ram_rbits;

    logic                 in_acc;
    logic                 cfg_mem_wr;
    logic                 size_bad;
    logic                 ev_match, ev_exact;
    logic                 scan_last;
    logic                 table_full;
    logic                 hit_has_hi;
    logic [CNT_BITS-1:0]  merge_src;
    logic                 merge_shift;
    logic [CNT_BITS-1:0]  count_drop;
    logic                 shift_end_up, shift_end_dn;

    ffa_ram #(.WIDTH(SEG_BITS), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rbits)
    );
    assign ram_rdata = seg_t'(ram_rbits);

    assign in_ready      = (state_reg == S_IDLE);
    assign in_acc        = in_valid && in_ready;
    assign out_valid     = (state_reg == S_OUT);
    assign status        = st_reg;
    assign granted_addr  = ga_reg;
    assign granted_bytes = gb_reg;
    assign used_bytes    = total_reg;
    assign cfg_mem_wr    = cfg_we && (cfg_index == CFG_MEM_BYTES);

    // zero bytes or a product beyond the address range never fits
    assign size_bad   = (want_reg == '0) || (want_reg[22:16] != '0);
    assign ev_match   = func_reg ? (!ram_rdata.free && ram_rdata.start == base_reg)
                                 : (ram_rdata.free && ram_rdata.size >= want_reg[15:0]);
    assign ev_exact   = ram_rdata.size == want_reg[15:0];
    assign scan_last  = (CNT_BITS'(idx_reg) + CNT_BITS'(1)) >= count_reg;
    assign table_full = count_reg == CNT_BITS'(MAX_SEGMENTS);
    assign hit_has_hi = (CNT_BITS'(hit_reg) + CNT_BITS'(1)) < count_reg;

    // merges remove a contiguous run: the freed entry and/or the one above it
    assign merge_src   = CNT_BITS'(hit_reg) + CNT_BITS'(1) + CNT_BITS'(hi_mg_reg);
    assign merge_shift = (lo_mg_reg || hi_mg_reg) && (merge_src < count_reg);
    assign count_drop  = count_reg - CNT_BITS'(lo_mg_reg) - CNT_BITS'(hi_mg_reg);

    assign shift_end_up = src_reg == (CNT_BITS'(hit_reg) + CNT_BITS'(1));
    assign shift_end_dn = (src_reg + CNT_BITS'(1)) >= count_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:     state_next = S_IDLE;
            S_IDLE:     if (in_acc) state_next = S_CHECK;
            S_CHECK:    state_next = (!func_reg && size_bad) ? S_OUT : S_SCAN_RD;
            S_SCAN_RD:  state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                if (ev_match)
                begin
                    if (func_reg)
                        state_next = (idx_reg != '0) ? S_LO_RD
                                   : (scan_last ? S_MERGE_WR : S_HI_RD);
                    else if (ev_exact || table_full)
                        state_next = S_OUT;
                    else if (scan_last)
                        state_next = S_INS;
                    else
                        state_next = S_SHIFT_RD;
                end
                else if (scan_last)
                    state_next = S_OUT;
                else
                    state_next = S_SCAN_RD;
            end
            S_LO_RD:    state_next = S_LO_EV;
            S_LO_EV:    state_next = hit_has_hi ? S_HI_RD : S_MERGE_WR;
            S_HI_RD:    state_next = S_HI_EV;
            S_HI_EV:    state_next = S_MERGE_WR;
            S_MERGE_WR: state_next = merge_shift ? S_SHIFT_RD : S_OUT;
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR:
            begin
                if (up_reg)
                    state_next = shift_end_up ? S_INS : S_SHIFT_RD;
                else
                    state_next = shift_end_dn ? S_OUT : S_SHIFT_RD;
            end
            S_INS:      state_next = S_OUT;
            S_OUT:      if (out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        if (cfg_mem_wr)
        begin
            state_next = S_INIT;
        end
    end

    // datapath and memory control
    always_comb
    begin
        count_next = count_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        up_next    = up_reg;
        lo_mg_next = lo_mg_reg;
        hi_mg_next = hi_mg_reg;
        cur_next   = cur_reg;
        rem_next   = rem_reg;
        st_next    = st_reg;
        ga_next    = ga_reg;
        gb_next    = gb_reg;
        ram_we     = 1'b0;
        ram_addr   = idx_reg;
        ram_wdata  = '0;
        case (state_reg)
            S_INIT:
            begin
                ram_we     = 1'b1;
                ram_addr   = '0;
                ram_wdata  = seg_t'{'0, mem_bytes_reg, 1'b1};
                count_next = CNT_BITS'(1);
                total_next = '0;
            end
            S_IDLE:
            begin
                idx_next = '0;
            end
            S_CHECK:
            begin
                st_next    = func_reg ? ST_NOTALLOC : ST_NOFIT;
                ga_next    = '0;
                gb_next    = '0;
                lo_mg_next = 1'b0;
                hi_mg_next = 1'b0;
            end
            S_SCAN_EV:
            begin
                idx_next = idx_reg + IDX_BITS'(1);
                hit_next = idx_reg;
                if (ev_match)
                begin
                    if (func_reg)
                    begin
                        st_next    = ST_OK;
                        ga_next    = ram_rdata.start;
                        gb_next    = ram_rdata.size;
                        total_next = total_reg - ram_rdata.size;
                        cur_next   = seg_t'{ram_rdata.start, ram_rdata.size, 1'b1};
                    end
                    else if (ev_exact)
                    begin
                        st_next    = ST_OK;
                        ga_next    = ram_rdata.start;
                        gb_next    = want_reg[15:0];
                        total_next = total_reg + want_reg[15:0];
                        ram_we     = 1'b1;
                        ram_wdata  = seg_t'{ram_rdata.start, ram_rdata.size, 1'b0};
                    end
                    else if (table_full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        // taken part written now, remainder after the move
                        st_next    = ST_OK;
                        ga_next    = ram_rdata.start;
                        gb_next    = want_reg[15:0];
                        total_next = total_reg + want_reg[15:0];
                        ram_we     = 1'b1;
                        ram_wdata  = seg_t'{ram_rdata.start, want_reg[15:0], 1'b0};
                        rem_next   = seg_t'{ram_rdata.start + want_reg[15:0],
                                            ram_rdata.size - want_reg[15:0], 1'b1};
                        up_next    = 1'b1;
                        src_next   = count_reg - CNT_BITS'(1);
                        dst_next   = count_reg;
                    end
                end
            end
            S_LO_RD:
            begin
                ram_addr = hit_reg - IDX_BITS'(1);
            end
            S_LO_EV:
            begin
                if (ram_rdata.free)
                begin
                    cur_next   = seg_t'{ram_rdata.start, ram_rdata.size + cur_reg.size, 1'b1};
                    lo_mg_next = 1'b1;
                end
            end
            S_HI_RD:
            begin
                ram_addr = hit_reg + IDX_BITS'(1);
            end
            S_HI_EV:
            begin
                if (ram_rdata.free)
                begin
                    cur_next   = seg_t'{cur_reg.start, cur_reg.size + ram_rdata.size, 1'b1};
                    hi_mg_next = 1'b1;
                end
            end
            S_MERGE_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = lo_mg_reg ? (hit_reg - IDX_BITS'(1)) : hit_reg;
                ram_wdata = cur_reg;
                up_next   = 1'b0;
                src_next  = merge_src;
                dst_next  = lo_mg_reg ? CNT_BITS'(hit_reg)
                                      : (CNT_BITS'(hit_reg) + CNT_BITS'(1));
                if (!merge_shift)
                    count_next = count_drop;
            end
            S_SHIFT_RD:
            begin
                ram_addr = src_reg[IDX_BITS-1:0];
            end
            S_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_addr  = dst_reg[IDX_BITS-1:0];
                ram_wdata = ram_rdata;
                if (up_reg)
                begin
                    src_next = src_reg - CNT_BITS'(1);
                    dst_next = dst_reg - CNT_BITS'(1);
                end
                else
                begin
                    src_next = src_reg + CNT_BITS'(1);
                    dst_next = dst_reg + CNT_BITS'(1);
                    if (shift_end_dn)
                        count_next = count_drop;
                end
            end
            S_INS:
            begin
                ram_we     = 1'b1;
                ram_addr   = hit_reg + IDX_BITS'(1);
                ram_wdata  = rem_reg;
                count_next = count_reg + CNT_BITS'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            mem_bytes_reg <= 16'd4096;
            elem_reg      <= 7'd24;
            count_reg     <= CNT_BITS'(1);
            total_reg     <= '0;
            idx_reg       <= '0;
            hit_reg       <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            up_reg        <= 1'b0;
            lo_mg_reg     <= 1'b0;
            hi_mg_reg     <= 1'b0;
            cur_reg       <= '0;
            rem_reg       <= '0;
            st_reg        <= ST_OK;
            ga_reg        <= '0;
            gb_reg        <= '0;
            func_reg      <= 1'b0;
            base_reg      <= '0;
            want_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            idx_reg   <= idx_next;
            hit_reg   <= hit_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            up_reg    <= up_next;
            lo_mg_reg <= lo_mg_next;
            hi_mg_reg <= hi_mg_next;
            cur_reg   <= cur_next;
            rem_reg   <= rem_next;
            st_reg    <= st_next;
            ga_reg    <= ga_next;
            gb_reg    <= gb_next;
            if (in_acc)
            begin
                func_reg <= func;
                base_reg <= base_addr;
                want_reg <= {7'd0, elem_count} * {16'd0, elem_reg};
            end
            if (cfg_mem_wr)
            begin
                mem_bytes_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_ELEMENT_BYTES)
            begin
                elem_reg <= cfg_data[6:0];
            end
        end
    end

    // a result word is never shown while a request is being taken
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready and valid overlap");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= CNT_BITS'(MAX_SEGMENTS))
        else $error("segment count out of range");
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> granted_bytes == '0 && granted_addr == '0)
        else $error("failed request reports a segment");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(granted_addr) && $stable(granted_bytes) && $stable(used_bytes))
        else $error("result word changed while stalled");

endmodule

### tb/first_fit_allocator_coalescing_top_test.sv
`timescale 1ns / 1ps
// Testbench for the first-fit segment allocator: predictor, driver, monitor and checks.
module first_fit_allocator_coalescing_top_test
    import ffa_pkg::*;
();

    typedef struct {
        logic        func;
        logic [15:0] elem_count;
        logic [15:0] base_addr;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] granted_addr;
        logic [15:0] granted_bytes;
        logic [15:0] used_bytes;
    } answer_t;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        func;
    logic [15:0] elem_count;
    logic [15:0] base_addr;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [15:0] granted_addr;
    logic [15:0] granted_bytes;
    logic [15:0] used_bytes;

    first_fit_allocator_coalescing_top u_dut (.*);

    // Shadow copy of the segment table.
    logic [15:0] mem_size;
    logic [6:0]  elem_size;
    logic [15:0] tbl_start [MAX_SEGMENTS];
    logic [15:0] tbl_size  [MAX_SEGMENTS];
    logic        tbl_free  [MAX_SEGMENTS];
    int          tbl_count;
    logic [15:0] total_used;

    request_t pending_words[$];
    answer_t  expected_answers[$];
    logic     [15:0] live_bases[$];   // guessed starts (element-size multiples), for realistic frees
    int       errors;
    longint   cycles;

    function automatic void table_clear();
        for (int k = 0; k < MAX_SEGMENTS; k++)
        begin
            tbl_start[k] = '0;
            tbl_size[k]  = '0;
            tbl_free[k]  = 1'b0;
        end
        tbl_size[0] = mem_size;
        tbl_free[0] = 1'b1;
        tbl_count   = 1;
        total_used  = '0;
    endfunction

    function automatic void drop_entry(int j);
        for (int k = j; k + 1 < tbl_count; k++)
        begin
            tbl_start[k] = tbl_start[k+1];
            tbl_size[k]  = tbl_size[k+1];
            tbl_free[k]  = tbl_free[k+1];
        end
        tbl_count--;
        tbl_start[tbl_count] = '0;
        tbl_size[tbl_count]  = '0;
        tbl_free[tbl_count]  = 1'b0;
    endfunction

    // Allocation: first fit, remainder goes right after the taken segment.
    function automatic answer_t predict_alloc(logic [15:0] num);
        answer_t a;
        longint  want;
        int      i;
        bit      found;
        want = longint'(num) * longint'(elem_size);
        a = '{ST_NOFIT, 16'd0, 16'd0, total_used};
        if (want == 0 || want > 65535)
            return a;
        found = 0;
        for (i = 0; i < tbl_count && !found; i++)
        begin
            if (tbl_free[i] && longint'(tbl_size[i]) >= want)
            begin
                found = 1;
                if (tbl_size[i] > want)
                begin
                    if (tbl_count >= MAX_SEGMENTS)
                    begin
                        a.status = ST_FULL;
                        return a;
                    end
                    for (int k = tbl_count; k > i + 1; k--)
                    begin
                        tbl_start[k] = tbl_start[k-1];
                        tbl_size[k]  = tbl_size[k-1];
                        tbl_free[k]  = tbl_free[k-1];
                    end
                    tbl_start[i+1] = tbl_start[i] + want[15:0];
                    tbl_size[i+1]  = tbl_size[i] - want[15:0];
                    tbl_free[i+1]  = 1'b1;
                    tbl_count++;
                    tbl_size[i] = want[15:0];
                end
                tbl_free[i] = 1'b0;
                total_used  = total_used + want[15:0];
                a = '{ST_OK, tbl_start[i], want[15:0], total_used};
            end
        end
        return a;
    endfunction

    // Free: release, then merge with a free left and a free right neighbor.
    function automatic answer_t predict_free(logic [15:0] base);
        answer_t a;
        int      i;
        i = 0;
        while (i < tbl_count && !(!tbl_free[i] && tbl_start[i] == base))
            i++;
        if (i >= tbl_count)
        begin
            a = '{ST_NOTALLOC, 16'd0, 16'd0, total_used};
            return a;
        end
        total_used = total_used - tbl_size[i];
        a = '{ST_OK, tbl_start[i], tbl_size[i], total_used};
        tbl_free[i] = 1'b1;
        if (i > 0 && tbl_free[i-1])
        begin
            tbl_size[i-1] = tbl_size[i-1] + tbl_size[i];
            drop_entry(i);
            i--;
        end
        if (i + 1 < tbl_count && tbl_free[i+1])
        begin
            tbl_size[i] = tbl_size[i] + tbl_size[i+1];
            drop_entry(i + 1);
        end
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: pops one word at a time, with random gaps between words.
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            func       <= 1'b0;
            elem_count <= '0;
            base_addr  <= '0;
            send_gap   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            // Word just taken, or line idle: decide about the next one.
            if (send_gap > 0 || pending_words.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                request_t w;
                answer_t  p;
                w = pending_words.pop_front();
                in_valid   <= 1'b1;
                func       <= w.func;
                elem_count <= w.elem_count;
                base_addr  <= w.base_addr;
                send_gap   <= pick_gap();
                // Prediction at send time; the block handles words in order.
                if (w.func == 1'b0)
                    p = predict_alloc(w.elem_count);
                else
                    p = predict_free(w.base_addr);
                expected_answers = {expected_answers, p};
            end
        end
    end

    // Monitor: random back-pressure and field-by-field compare.
    int stall;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall     <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (status !== e.status)
                    begin
                        $error("status exp %0d got %0d", e.status, status);
                        errors++;
                    end
                    if (granted_addr !== e.granted_addr)
                    begin
                        $error("granted_addr exp %0d got %0d", e.granted_addr,
                               granted_addr);
                        errors++;
                    end
                    if (granted_bytes !== e.granted_bytes)
                    begin
                        $error("granted_bytes exp %0d got %0d", e.granted_bytes,
                               granted_bytes);
                        errors++;
                    end
                    if (used_bytes !== e.used_bytes)
                    begin
                        $error("used_bytes exp %0d got %0d", e.used_bytes, used_bytes);
                        errors++;
                    end
                end
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall     <= stall - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                stall     <= pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_word(logic f, logic [15:0] n, logic [15:0] b);
        request_t w;
        w = '{f, n, b};
        pending_words = {pending_words, w};
    endtask

    // Wait until every queued word has been answered, then let the block settle.
    task automatic drain();
        while (pending_words.size() != 0 || in_valid || expected_answers.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // Register writes only while idle; mirror them in the predictor.
    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MEM_BYTES)
        begin
            mem_size = value;
            table_clear();
        end
        else
            elem_size = value[6:0];
        // Room for the table rewrite after a size write.
        repeat (MAX_SEGMENTS + 8) @(posedge clk);
    endtask

    // One random phase: mostly alloc/free of live segments, some noise.
    task automatic random_phase(int count);
        logic [15:0] n;
        live_bases.delete();
        for (int k = 0; k < count; k++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                n = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 12));
                queue_word(1'b0, n, 16'($urandom));
            end
            else if (r < 85 && live_bases.size() != 0)
            begin
                int j;
                j = $urandom_range(0, live_bases.size() - 1);
                queue_word(1'b1, 16'($urandom), live_bases[j]);
                live_bases.delete(j);
            end
            else
                queue_word(1'b1, 16'($urandom), 16'($urandom));
            // Track candidate starts: any multiple of the element size is plausible.
            if (r < 45)
                live_bases = {live_bases, 16'(elem_size * $urandom_range(0, 40))};
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        mem_size  = 16'd4096;
        elem_size = 7'd24;
        table_clear();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MAX_SEGMENTS + 8) @(posedge clk);

        // Directed: reset settings, exact fit, split, merges, bad frees.
        queue_word(1'b0, 16'd1, 16'd0);          // 24 bytes at 0
        queue_word(1'b0, 16'd2, 16'hFFFF);       // 48 bytes at 24
        queue_word(1'b0, 16'd1, 16'd0);          // 24 bytes at 72
        queue_word(1'b1, 16'd0, 16'd24);         // free middle
        queue_word(1'b1, 16'd0, 16'd24);         // already free
        queue_word(1'b1, 16'hFFFF, 16'd5);       // unknown start
        queue_word(1'b1, 16'd0, 16'd0);          // merges right
        queue_word(1'b1, 16'd0, 16'd72);         // merges both sides
        queue_word(1'b0, 16'hFFFF, 16'd0);       // oversized
        queue_word(1'b0, 16'd0, 16'd0);          // zero count
        for (int k = 0; k < 16; k++)             // fill table, then table full
            queue_word(1'b0, 16'd1, 16'd0);
        drain();
        // Pause before configuration: sender holds until all results are in.

        write_reg(CFG_ELEMENT_BYTES, 16'd0);
        queue_word(1'b0, 16'd5, 16'd0);           // zero element size
        drain();
        write_reg(CFG_MEM_BYTES, 16'd0);
        write_reg(CFG_ELEMENT_BYTES, 16'd1);
        queue_word(1'b0, 16'd1, 16'd0);           // zero memory
        drain();
        write_reg(CFG_MEM_BYTES, 16'hFFFF);
        queue_word(1'b0, 16'hFFFF, 16'd0);        // exact fit of whole memory
        queue_word(1'b1, 16'd0, 16'd0);
        drain();

        // Random phases across settings, extremes included.
        write_reg(CFG_ELEMENT_BYTES, 16'd64);
        write_reg(CFG_MEM_BYTES, 16'd2048);
        random_phase(200);
        drain();
        write_reg(CFG_ELEMENT_BYTES, 16'd1);
        write_reg(CFG_MEM_BYTES, 16'd64);
        random_phase(200);
        drain();
        write_reg(CFG_ELEMENT_BYTES, 16'd24);
        write_reg(CFG_MEM_BYTES, 16'hFFFF);
        random_phase(200);
        drain();
        write_reg(CFG_ELEMENT_BYTES, 16'($urandom_range(1, 127)));
        write_reg(CFG_MEM_BYTES, 16'($urandom_range(1, 1000)));
        random_phase(200);
        drain();

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ffa_pkg.sv
rtl/ffa_ram.sv
rtl/first_fit_allocator_coalescing_top.sv
tb/first_fit_allocator_coalescing_top_test.sv
